>>> src/line_color_gradient_assert.svh
// assertion macros for the line color gradient block
`ifndef LINE_COLOR_GRADIENT_ASSERT_SVH
`define LINE_COLOR_GRADIENT_ASSERT_SVH
`ifndef ASSERT_OFF
// clocked assertion on clk_i, off while rst_ni is low
`define LCG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// same-cycle implication
`define LCG_ASSERT_IMPL(lbl, ante, cons, msg) \
  `LCG_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define LCG_ASSERT(lbl, prop, msg)
`define LCG_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

>>> src/lcg_pkg.sv
// shared constants and types of the line color gradient block
package lcg_pkg;

  localparam int COLOR_BITS = 24;
  localparam int CHAN_BITS  = 8;
  localparam int NUM_CHAN   = 3;
  // end minus start of one channel, signed
  localparam int DE_BITS    = CHAN_BITS + 1;
  // quotient bits per channel, the top one flags saturation
  localparam int QUO_BITS   = CHAN_BITS + 1;
  localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hFF;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

>>> src/lcg_fifo.sv
// small first-word-fall-through queue with full and empty status
module lcg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     data_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     data_o,
  output lcg_pkg::fifo_status_t status_o
);
  import lcg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/lcg_front.sv
// front end: picks the major axis, forms position and span, flags bypass cases
module lcg_front #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [COORD_BITS-1:0]                       cur_x_i,
  input  logic signed [COORD_BITS-1:0]                       cur_y_i,
  input  logic [lcg_pkg::COLOR_BITS-1:0]                     cur_color_i,
  input  logic signed [COORD_BITS-1:0]                       start_x_i,
  input  logic signed [COORD_BITS-1:0]                       start_y_i,
  input  logic [lcg_pkg::COLOR_BITS-1:0]                     start_color_i,
  input  logic signed [COORD_BITS-1:0]                       end_x_i,
  input  logic signed [COORD_BITS-1:0]                       end_y_i,
  input  logic [lcg_pkg::COLOR_BITS-1:0]                     end_color_i,
  input  logic signed [COORD_BITS:0]                         delta_x_i,
  input  logic signed [COORD_BITS:0]                         delta_y_i,
  output logic                                               bypass_o,
  output logic [lcg_pkg::COLOR_BITS-1:0]                     byp_color_o,
  output logic signed [COORD_BITS:0]                         pos_o,
  output logic [COORD_BITS-1:0]                              dist_o,
  output logic [lcg_pkg::NUM_CHAN*lcg_pkg::CHAN_BITS-1:0]    s_o,
  output logic [lcg_pkg::NUM_CHAN*lcg_pkg::DE_BITS-1:0]      de_o
);
  import lcg_pkg::*;

  logic                    x_major, same_color;
  logic signed [COORD_BITS:0] pos_raw, dist_raw;

  assign x_major    = delta_x_i > delta_y_i;
  assign same_color = (cur_color_i == end_color_i);

  always_comb begin
    if (x_major) begin
      pos_raw  = (COORD_BITS+1)'(cur_x_i) - (COORD_BITS+1)'(start_x_i);
      dist_raw = (COORD_BITS+1)'(end_x_i) - (COORD_BITS+1)'(start_x_i);
    end else begin
      pos_raw  = (COORD_BITS+1)'(cur_y_i) - (COORD_BITS+1)'(start_y_i);
      dist_raw = (COORD_BITS+1)'(end_y_i) - (COORD_BITS+1)'(start_y_i);
    end
  end

  // fold the span sign into the position so the divisor is a magnitude
  always_comb begin
    if (dist_raw[COORD_BITS]) begin
      pos_o  = -pos_raw;
      dist_o = COORD_BITS'(-dist_raw);
    end else begin
      pos_o  = pos_raw;
      dist_o = dist_raw[COORD_BITS-1:0];
    end
  end

  assign bypass_o    = same_color || (dist_raw == '0);
  assign byp_color_o = same_color ? cur_color_i : end_color_i;
  assign s_o         = start_color_i;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      de_o[c*DE_BITS +: DE_BITS] = {1'b0, end_color_i[c*CHAN_BITS +: CHAN_BITS]}
                                 - {1'b0, start_color_i[c*CHAN_BITS +: CHAN_BITS]};
    end
  end

endmodule

>>> src/lcg_back.sv
// back end: multiply, add, and a restoring divide pipeline per channel
module lcg_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  input  logic                                            bypass_i,
  input  logic [lcg_pkg::COLOR_BITS-1:0]                  byp_color_i,
  input  logic signed [COORD_BITS:0]                      pos_i,
  input  logic [COORD_BITS-1:0]                           dist_i,
  input  logic [lcg_pkg::NUM_CHAN*lcg_pkg::CHAN_BITS-1:0] s_i,
  input  logic [lcg_pkg::NUM_CHAN*lcg_pkg::DE_BITS-1:0]   de_i,
  output logic                                            valid_o,
  output logic [lcg_pkg::COLOR_BITS-1:0]                  color_o
);
  import lcg_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int SW = W + CHAN_BITS;   // start times span
  localparam int PW = W + 10;          // signed numerator
  localparam int RW = W + 9;           // nonnegative remainder
  localparam int NQ = QUO_BITS;

  // multiply stage
  logic                 v1_q, byp1_q;
  logic [COLOR_BITS-1:0] bcol1_q;
  logic [W-1:0]         d1_q;
  logic [SW-1:0]        ps1_q [NUM_CHAN];
  logic signed [PW-1:0] pd1_q [NUM_CHAN];
  logic [SW-1:0]        ps_d  [NUM_CHAN];
  logic signed [PW-1:0] pd_d  [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      ps_d[c] = SW'(s_i[c*CHAN_BITS +: CHAN_BITS]) * SW'(dist_i);
      pd_d[c] = PW'(pos_i) * PW'($signed(de_i[c*DE_BITS +: DE_BITS]));
    end
  end

  // add stage (index 0) and one divide step per later index
  logic                  v_q    [NQ+1];
  logic                  byp_q  [NQ+1];
  logic [COLOR_BITS-1:0] bcol_q [NQ+1];
  logic [W-1:0]          d_q    [NQ+1];
  logic                  neg_q  [NQ+1][NUM_CHAN];
  logic [RW-1:0]         r_q    [NQ+1][NUM_CHAN];
  logic [NQ-1:0]         q_q    [NQ+1][NUM_CHAN];
  logic                  neg_d  [NQ+1][NUM_CHAN];
  logic [RW-1:0]         r_d    [NQ+1][NUM_CHAN];
  logic [NQ-1:0]         q_d    [NQ+1][NUM_CHAN];

  always_comb begin
    logic signed [PW-1:0] num;
    logic [RW:0]          trial;
    for (int c = 0; c < NUM_CHAN; c++) begin
      num         = $signed(PW'(ps1_q[c])) + pd1_q[c];
      neg_d[0][c] = num[PW-1];
      r_d[0][c]   = num[RW-1:0];
      q_d[0][c]   = '0;
    end
    // step i tries the divisor shifted up by NQ-i
    for (int i = 1; i <= NQ; i++) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        trial       = {1'b0, r_q[i-1][c]} - ((RW+1)'(d_q[i-1]) << (NQ - i));
        neg_d[i][c] = neg_q[i-1][c];
        q_d[i][c]   = q_q[i-1][c];
        if (!trial[RW]) begin
          r_d[i][c]          = trial[RW-1:0];
          q_d[i][c][NQ - i]  = 1'b1;
        end else begin
          r_d[i][c] = r_q[i-1][c];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      for (int i = 0; i <= NQ; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      v1_q   <= valid_i;
      v_q[0] <= v1_q;
      for (int i = 1; i <= NQ; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp1_q  <= bypass_i;
    bcol1_q <= byp_color_i;
    d1_q    <= dist_i;
    for (int c = 0; c < NUM_CHAN; c++) begin
      ps1_q[c] <= ps_d[c];
      pd1_q[c] <= pd_d[c];
    end
    byp_q[0]  <= byp1_q;
    bcol_q[0] <= bcol1_q;
    d_q[0]    <= d1_q;
    for (int i = 1; i <= NQ; i++) begin
      byp_q[i]  <= byp_q[i-1];
      bcol_q[i] <= bcol_q[i-1];
      d_q[i]    <= d_q[i-1];
    end
    for (int i = 0; i <= NQ; i++) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        neg_q[i][c] <= neg_d[i][c];
        r_q[i][c]   <= r_d[i][c];
        q_q[i][c]   <= q_d[i][c];
      end
    end
  end

  // clamp: negative numerator gives zero, top quotient bit saturates; a bypass passes its color through
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (neg_q[NQ][c]) begin
        color_o[c*CHAN_BITS +: CHAN_BITS] = '0;
      end else if (q_q[NQ][c][NQ-1]) begin
        color_o[c*CHAN_BITS +: CHAN_BITS] = CHAN_MAX;
      end else begin
        color_o[c*CHAN_BITS +: CHAN_BITS] = q_q[NQ][c][CHAN_BITS-1:0];
      end
    end
    if (byp_q[NQ]) begin
      color_o = bcol_q[NQ];
    end
  end

  assign valid_o = v_q[NQ];

endmodule

>>> src/line_color_gradient.sv
// line color gradient: per-pixel rgb888 interpolation along a line's major axis
// an accepted request passes through the mid queue, the back pipeline and the output queue
// throughput: one request per cycle while output credits last, through the 11-stage multiply/add/divide
//   pipeline whose divide is nine compare-subtract stages, one quotient bit each
// reset: clears both queues, the pipeline valid bits and the credit counter; no
//   clearing pass, the block takes requests in the first cycle after reset
module line_color_gradient #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_BITS-1:0]  cur_x_i,
  input  logic signed [COORD_BITS-1:0]  cur_y_i,
  input  logic [lcg_pkg::COLOR_BITS-1:0] cur_color_i,
  input  logic signed [COORD_BITS-1:0]  start_x_i,
  input  logic signed [COORD_BITS-1:0]  start_y_i,
  input  logic [lcg_pkg::COLOR_BITS-1:0] start_color_i,
  input  logic signed [COORD_BITS-1:0]  end_x_i,
  input  logic signed [COORD_BITS-1:0]  end_y_i,
  input  logic [lcg_pkg::COLOR_BITS-1:0] end_color_i,
  input  logic signed [COORD_BITS:0]    delta_x_i,
  input  logic signed [COORD_BITS:0]    delta_y_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [lcg_pkg::COLOR_BITS-1:0] pixel_color_o
);
  import lcg_pkg::*;

  // mid queue absorbs short bursts between front and back
  localparam int MID_DEPTH = 4;
  // back pipeline depth: multiply, add, then one stage per quotient bit
  localparam int BACK_LAT  = QUO_BITS + 2;
  // output queue must hold everything the back end may have in flight
  localparam int OUT_DEPTH = BACK_LAT + 4;
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);
  localparam int S_W       = NUM_CHAN * CHAN_BITS;
  localparam int DE_W      = NUM_CHAN * DE_BITS;
  localparam int MID_W     = 1 + COLOR_BITS + (COORD_BITS + 1) + COORD_BITS + S_W + DE_W;

  // front end outputs, straight from the request ports
  logic                          f_byp;
  logic [COLOR_BITS-1:0]         f_bcol;
  logic signed [COORD_BITS:0]    f_pos;
  logic [COORD_BITS-1:0]         f_dist;
  logic [S_W-1:0]                f_s;
  logic [DE_W-1:0]               f_de;

  // mid queue head as seen by the back end
  logic                          m_byp;
  logic [COLOR_BITS-1:0]         m_bcol;
  logic signed [COORD_BITS:0]    m_pos;
  logic [COORD_BITS-1:0]         m_dist;
  logic [S_W-1:0]                m_s;
  logic [DE_W-1:0]               m_de;
  logic [MID_W-1:0]              mid_dout;
  fifo_status_t                  mid_st;

  logic                          b_valid;
  logic [COLOR_BITS-1:0]         b_color;
  fifo_status_t                  out_st;

  // credits: requests in the back pipeline plus results in the output queue
  logic [CNT_W-1:0]              inflight_q, inflight_d;
  logic                          in_push, issue, out_pop;

  lcg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .cur_x_i      (cur_x_i),
    .cur_y_i      (cur_y_i),
    .cur_color_i  (cur_color_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .start_color_i(start_color_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .end_color_i  (end_color_i),
    .delta_x_i    (delta_x_i),
    .delta_y_i    (delta_y_i),
    .bypass_o     (f_byp),
    .byp_color_o  (f_bcol),
    .pos_o        (f_pos),
    .dist_o       (f_dist),
    .s_o          (f_s),
    .de_o         (f_de)
  );

  // a request enters when the mid queue has room
  assign in_push = push && !full;
  assign full    = mid_st.full;

  lcg_fifo #(
    .WIDTH(MID_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_push),
    .data_i  ({f_byp, f_bcol, f_pos, f_dist, f_s, f_de}),
    .pop_i   (issue),
    .data_o  (mid_dout),
    .status_o(mid_st)
  );

  assign {m_byp, m_bcol, m_pos, m_dist, m_s, m_de} = mid_dout;

  // issue only with a free output slot; a result leaving this cycle frees one
  assign out_pop = pop && !empty;
  assign issue   = !mid_st.empty && ((inflight_q != CNT_W'(OUT_DEPTH)) || out_pop);

  lcg_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (issue),
    .bypass_i   (m_byp),
    .byp_color_i(m_bcol),
    .pos_i      (m_pos),
    .dist_i     (m_dist),
    .s_i        (m_s),
    .de_i       (m_de),
    .valid_o    (b_valid),
    .color_o    (b_color)
  );

  // the back pipeline never stalls; credits keep this queue from overflowing
  lcg_fifo #(
    .WIDTH(COLOR_BITS),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_valid),
    .data_i  (b_color),
    .pop_i   (out_pop),
    .data_o  (pixel_color_o),
    .status_o(out_st)
  );

  assign empty = out_st.empty;

  assign inflight_d = inflight_q + CNT_W'(issue) - CNT_W'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

`include "line_color_gradient_assert.svh"

  `LCG_ASSERT(a_credit_bound, inflight_q <= CNT_W'(OUT_DEPTH), "credit count above queue depth")
  `LCG_ASSERT_IMPL(a_no_overflow, b_valid, !out_st.full, "result arrived at a full output queue")
  `LCG_ASSERT_IMPL(a_result_counted, !out_st.empty, inflight_q != '0, "queued result without credit")
  `LCG_ASSERT(a_credit_return, (out_pop && !issue) |=> (inflight_q == $past(inflight_q) - 1'b1), "credit not returned")

endmodule

>>> tb/sv/line_color_gradient_test.sv
// self-checking testbench for the line color gradient block
module line_color_gradient_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcg_pkg::*;

  localparam int COORD_BITS    = 16;
  // latency from the head of the block, plus a margin for the settle wait
  localparam int PIPE_LATENCY  = 12;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 8;
  // cycles with no request and no result accepted before the run is declared hung
  localparam int STALL_LIMIT   = 5000;
  // length of the long receiver hold-off that fills the block
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 10;

  // one pixel request, fields at the block's widths
  typedef struct {
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic [COLOR_BITS-1:0]        cur_color;
    logic signed [COORD_BITS-1:0] start_x, start_y;
    logic [COLOR_BITS-1:0]        start_color;
    logic signed [COORD_BITS-1:0] end_x, end_y;
    logic [COLOR_BITS-1:0]        end_color;
    logic signed [COORD_BITS:0]   delta_x, delta_y;
  } pixel_req_t;

  logic                  clk    = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push   = 1'b0;
  logic                  pop    = 1'b0;
  logic                  full;
  logic                  empty;
  logic [COLOR_BITS-1:0] pixel_color;
  // request currently on the input ports
  pixel_req_t            req_q = '{default: '0};

  // colors the block owes us, oldest first
  logic [COLOR_BITS-1:0] expected_colors[$];
  int                    error_count   = 0;
  int                    stall_cycles  = 0;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  // long hold-off: requested by a test, counted down by the receiver
  logic                  hold_req  = 1'b0;
  int                    hold_left = 0;

  line_color_gradient #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cur_x_i      (req_q.cur_x),
    .cur_y_i      (req_q.cur_y),
    .cur_color_i  (req_q.cur_color),
    .start_x_i    (req_q.start_x),
    .start_y_i    (req_q.start_y),
    .start_color_i(req_q.start_color),
    .end_x_i      (req_q.end_x),
    .end_y_i      (req_q.end_y),
    .end_color_i  (req_q.end_color),
    .delta_x_i    (req_q.delta_x),
    .delta_y_i    (req_q.delta_y),
    .empty        (empty),
    .pop          (pop),
    .pixel_color_o(pixel_color)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // color predictor, exact integer math on 64-bit signed values
  // ---------------------------------------------------------------------------

  // one channel: start + pos/span * (end - start), truncated toward zero, clamped
  function automatic logic [CHAN_BITS-1:0] blend_channel(longint s, longint e,
                                                          longint pos, longint span);
    longint v;
    if (span == 0) begin
      // zero span counts as the full way along
      v = e;
    end else begin
      v = (s * span + pos * (e - s)) / span;
    end
    if (v < 0) v = 0;
    if (v > longint'(CHAN_MAX)) v = longint'(CHAN_MAX);
    return v[CHAN_BITS-1:0];
  endfunction

  function automatic logic [COLOR_BITS-1:0] gradient_color(pixel_req_t r);
    longint                pos, span;
    logic [COLOR_BITS-1:0] c;
    // pixel already at the end color passes through untouched
    if (r.cur_color == r.end_color) return r.cur_color;
    // x is the major axis only when its delta is strictly larger
    if (r.delta_x > r.delta_y) begin
      pos  = longint'(r.cur_x) - longint'(r.start_x);
      span = longint'(r.end_x) - longint'(r.start_x);
    end else begin
      pos  = longint'(r.cur_y) - longint'(r.start_y);
      span = longint'(r.end_y) - longint'(r.start_y);
    end
    for (int i = 0; i < NUM_CHAN; i++) begin
      c[i*CHAN_BITS +: CHAN_BITS] =
        blend_channel(longint'(r.start_color[i*CHAN_BITS +: CHAN_BITS]),
                      longint'(r.end_color[i*CHAN_BITS +: CHAN_BITS]), pos, span);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------

  function automatic pixel_req_t line_req(int cx, int cy, logic [COLOR_BITS-1:0] cc,
                                          int sx, int sy, logic [COLOR_BITS-1:0] sc,
                                          int ex, int ey, logic [COLOR_BITS-1:0] ec,
                                          int dx, int dy);
    pixel_req_t r;
    r.cur_x       = COORD_BITS'(cx);
    r.cur_y       = COORD_BITS'(cy);
    r.cur_color   = cc;
    r.start_x     = COORD_BITS'(sx);
    r.start_y     = COORD_BITS'(sy);
    r.start_color = sc;
    r.end_x       = COORD_BITS'(ex);
    r.end_y       = COORD_BITS'(ey);
    r.end_color   = ec;
    r.delta_x     = (COORD_BITS+1)'(dx);
    r.delta_y     = (COORD_BITS+1)'(dy);
    return r;
  endfunction

  // random color, biased toward all-black and all-white
  function automatic logic [COLOR_BITS-1:0] random_color();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return COLOR_BITS'($urandom);
    endcase
  endfunction

  // mostly a pixel on or near a real line, sometimes pure noise
  function automatic pixel_req_t random_pixel();
    pixel_req_t r;
    int         lim, base, sx, sy, ex, ey, dx, dy, k;
    if ($urandom_range(99) < 15) begin
      r.cur_x       = COORD_BITS'($urandom);
      r.cur_y       = COORD_BITS'($urandom);
      r.cur_color   = COLOR_BITS'($urandom);
      r.start_x     = COORD_BITS'($urandom);
      r.start_y     = COORD_BITS'($urandom);
      r.start_color = COLOR_BITS'($urandom);
      r.end_x       = COORD_BITS'($urandom);
      r.end_y       = COORD_BITS'($urandom);
      r.end_color   = COLOR_BITS'($urandom);
      r.delta_x     = (COORD_BITS+1)'($urandom);
      r.delta_y     = (COORD_BITS+1)'($urandom);
      if ($urandom_range(3) == 0) r.cur_color = r.end_color;
      return r;
    end
    // most lines short, a few nearly the whole coordinate range
    lim  = ($urandom_range(9) == 0) ? 30000 : 200;
    base = (lim > 1000) ? 2000 : 30000;
    sx = int'($urandom_range(2 * base)) - base;
    sy = int'($urandom_range(2 * base)) - base;
    ex = sx + int'($urandom_range(2 * lim)) - lim;
    ey = sy + int'($urandom_range(2 * lim)) - lim;
    if ($urandom_range(19) == 0) begin
      ex = sx;
      ey = sy;
    end
    dx = ex - sx;
    dy = ey - sy;
    // position along the line in 1/256 steps, a little past both ends
    k = int'($urandom_range(288)) - 16;
    r.start_x = COORD_BITS'(sx);
    r.start_y = COORD_BITS'(sy);
    r.end_x   = COORD_BITS'(ex);
    r.end_y   = COORD_BITS'(ey);
    r.cur_x   = COORD_BITS'(sx + dx * k / 256);
    r.cur_y   = COORD_BITS'(sy + dy * k / 256);
    // rasterizers usually pass absolute extents, sometimes signed ones
    if ($urandom_range(3) == 0) begin
      r.delta_x = (COORD_BITS+1)'(dx);
      r.delta_y = (COORD_BITS+1)'(dy);
    end else begin
      r.delta_x = (COORD_BITS+1)'((dx < 0) ? -dx : dx);
      r.delta_y = (COORD_BITS+1)'((dy < 0) ? -dy : dy);
    end
    if ($urandom_range(15) == 0) r.delta_y = r.delta_x;
    r.start_color = random_color();
    r.end_color   = random_color();
    r.cur_color   = ($urandom_range(9) == 0) ? r.end_color : random_color();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus the long hold-off, pop changes at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: records accepted requests and checks each result at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [COLOR_BITS-1:0] want;
    if (rst_ni) begin
      if (push && !full) begin
        expected_colors.push_back(gradient_color(req_q));
      end
      if (!empty && pop) begin
        if (expected_colors.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("unexpected pixel color %06h with no request pending", pixel_color);
        end else begin
          want = expected_colors.pop_front();
          if (pixel_color !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("pixel color mismatch: expected %06h, got %06h", want, pixel_color);
          end
        end
      end
      if ((push && !full) || (!empty && pop)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // watchdog on cycles with no progress in either direction
  initial begin
    @(posedge clk);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // sender side, called and returning at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input pixel_req_t r);
    // idle cycles carry junk on the fields, the block has to ignore it
    while ($urandom_range(99) < send_idle_pct) begin
      push  <= 1'b0;
      req_q <= random_pixel();
      @(negedge clk);
    end
    push  <= 1'b1;
    req_q <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // sender pauses until every owed color is back and the pipeline has settled
  task automatic wait_for_drain();
    push <= 1'b0;
    while (expected_colors.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // pixel already at the end color, including where interpolation would differ
  task automatic test_end_color_match();
    send_pixel(line_req(5, 7, 24'h123456, 0, 0, 24'h000000, 10, 10, 24'h123456, 10, 10));
    send_pixel(line_req(-900, 400, 24'hFFFFFF, 0, 0, 24'h000000, 3, 3, 24'hFFFFFF, 3, 3));
    send_pixel(line_req(2, 2, 24'h000000, 2, 2, 24'hFFFFFF, 2, 2, 24'h000000, 0, 0));
    wait_for_drain();
  endtask

  // start equals end on the major axis gives the end color
  task automatic test_zero_span();
    // x major with zero x span, y span nonzero
    send_pixel(line_req(100, -3, 24'h000000, 40, 9, 24'hABCDEF, 40, 90, 24'h135790, 0, -1));
    // y major with zero y span, x span nonzero
    send_pixel(line_req(7, 77, 24'h010203, -5, 20, 24'hFF00FF, 50, 20, 24'h00FF00, 4, 9));
    wait_for_drain();
  endtask

  // coordinates and deltas at the ends of their ranges
  task automatic test_coord_extremes();
    send_pixel(line_req(0, 0, 24'h000000, -32768, 0, 24'h00FF80, 32767, 0, 24'h80FF00,
                        65535, 0));
    send_pixel(line_req(32767, -32768, 24'h000000, -32768, 32767, 24'hFFFFFF,
                        32767, -32768, 24'h000000, 65535, -65535));
    send_pixel(line_req(-32768, -1, 24'h000001, 32767, -32768, 24'h00FF00,
                        -32768, 32767, 24'hFF00FF, -65535, 65535));
    // most negative delta bit pattern against the largest positive one
    send_pixel(line_req(100, -200, 24'h000000, -32768, 32767, 24'h7F7F7F,
                        32767, -32768, 24'h808080, -65536, 65535));
    send_pixel(line_req(-1, 1, 24'h000000, -32768, -32768, 24'hFFFFFF,
                        -32768, 32767, 24'h000000, 65535, 65535));
    wait_for_drain();
  endtask

  // x major only on a strict win, equal deltas pick y
  task automatic test_axis_choice();
    // x fraction a quarter, y fraction three quarters
    send_pixel(line_req(25, 75, 24'h000000, 0, 0, 24'h000000, 100, 100, 24'hC8C8C8, 50, 50));
    send_pixel(line_req(25, 75, 24'h000000, 0, 0, 24'h000000, 100, 100, 24'hC8C8C8, 51, 50));
    send_pixel(line_req(25, 75, 24'h000000, 0, 0, 24'h000000, 100, 100, 24'hC8C8C8, -5, -6));
    send_pixel(line_req(25, 75, 24'h000000, 0, 0, 24'h000000, 100, 100, 24'hC8C8C8, -6, -5));
    wait_for_drain();
  endtask

  // extrapolation past either end, clamping and truncation toward zero
  task automatic test_outside_segment();
    // past the end, climbs over 255
    send_pixel(line_req(30, 0, 24'h000000, 0, 0, 24'h0A0A0A, 10, 0, 24'hC8C8C8, 10, 0));
    // before the start, drops under 0
    send_pixel(line_req(-30, 0, 24'h000000, 0, 0, 24'h0A0A0A, 10, 0, 24'hC8C8C8, 10, 0));
    // fractional thirds on a descending channel
    send_pixel(line_req(0, 1, 24'h000000, 0, 0, 24'h640064, 0, 3, 24'h006400, 0, 3));
    // negative span, negative position
    send_pixel(line_req(0, -1, 24'h000000, 0, 0, 24'h000000, 0, -3, 24'h646464, 0, 3));
    send_pixel(line_req(0, -2, 24'h000001, 0, 0, 24'hFF0000, 0, -3, 24'h00FF64, 0, 3));
    // black to white, one step outside each end
    send_pixel(line_req(-1, 0, 24'h123456, 0, 0, 24'h000000, 7, 0, 24'hFFFFFF, 7, 0));
    send_pixel(line_req(8, 0, 24'h123456, 0, 0, 24'h000000, 7, 0, 24'hFFFFFF, 7, 0));
    wait_for_drain();
  endtask

  task automatic test_random_lines(input int count);
    repeat (count) send_pixel(random_pixel());
    wait_for_drain();
  endtask

  // receiver holds off while requests keep coming, so the block fills and stalls
  task automatic test_queue_full();
    set_idling(0, 0);
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    repeat (150) send_pixel(random_pixel());
    wait_for_drain();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    set_idling(0, 0);
    test_end_color_match();
    test_zero_span();
    test_coord_extremes();
    test_axis_choice();
    test_outside_segment();

    // random lines through each idling pattern
    set_idling(0, 0);
    test_random_lines(240);
    set_idling(87, 0);
    test_random_lines(240);
    set_idling(0, 87);
    test_random_lines(240);
    set_idling(36, 36);
    test_random_lines(240);

    test_queue_full();

    wait_for_drain();
    if (error_count == 0 && expected_colors.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/lcg_pkg.sv
src/lcg_fifo.sv
src/lcg_front.sv
src/lcg_back.sv
src/line_color_gradient.sv
tb/sv/line_color_gradient_test.sv
